/* rtl/core/bam_pkg.sv */
// Shared types and constants for the button mode lamp animator.
// Payload structs, state enums, event codes and register indexes.
// No dependencies.
package bam_pkg;

    localparam int TIMER_W   = 16;
    localparam int LAMPS_W   = 5;
    localparam int MODE_W    = 3;
    localparam int EVENT_W   = 2;
    localparam int PICK_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_WAIT     = 2'd3
    } t_phase;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 3'd0,
        MODE_ON     = 3'd1,
        MODE_TOGGLE = 3'd2,
        MODE_SWEEP  = 3'd3,
        MODE_RANDOM = 3'd4
    } t_mode;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_TOGGLE     = 3'd2,
        REG_SWEEP      = 3'd3,
        REG_RANDOM     = 3'd4
    } t_reg_idx;

    localparam logic [TIMER_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [TIMER_W-1:0] LONG_PRESS_RST = 16'd3000;
    localparam logic [TIMER_W-1:0] TOGGLE_RST     = 16'd200;
    localparam logic [TIMER_W-1:0] SWEEP_RST      = 16'd100;
    localparam logic [TIMER_W-1:0] RANDOM_RST     = 16'd150;

    typedef struct packed {
        logic              button_level;
        logic [PICK_W-1:0] random_pick;
    } t_in_item;

    typedef struct packed {
        logic [LAMPS_W-1:0] lamps;
        logic [MODE_W-1:0]  mode;
        logic [EVENT_W-1:0] press_event;
    } t_out_item;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
        return (t == TIMER_MAX) ? TIMER_MAX : t + 16'd1;
    endfunction

endpackage

/* rtl/core/bam_button.sv */
// Button machine: idle, debounce, pressed, wait-release with a saturating timer.
// Classifies each tick as no event, short press or long press.
// Depends on bam_pkg.
module bam_button (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_pressed,
    input  logic [bam_pkg::TIMER_W-1:0]   i_debounce_ticks,
    input  logic [bam_pkg::TIMER_W-1:0]   i_long_press_ticks,
    output bam_pkg::t_event               o_event
);
    import bam_pkg::*;

    t_phase               r_phase, n_phase;
    logic [TIMER_W-1:0]   r_timer, n_timer;
    t_event               n_event;

    always_comb begin
        n_timer = sat_inc(r_timer);
        n_phase = r_phase;
        n_event = EV_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (i_pressed) begin
                    n_timer = '0;
                    n_phase = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (n_timer >= i_debounce_ticks) begin
                    if (i_pressed) begin
                        n_timer = '0;
                        n_phase = PH_PRESSED;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_PRESSED: begin
                if (!i_pressed) begin
                    n_phase = PH_IDLE;
                    n_event = EV_SHORT;
                end else if (n_timer >= i_long_press_ticks) begin
                    n_phase = PH_WAIT;
                    n_event = EV_LONG;
                end
            end
            default: begin
                if (!i_pressed) begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    assign o_event = n_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
        end
    end

endmodule

/* rtl/core/bam_anim.sv */
// Mode register and lamp animation: on, toggle, back-and-forth sweep, random lamp.
// Applies press events first, then runs the animation of the resulting mode.
// Depends on bam_pkg.
module bam_anim #(
    parameter int LAMP_COUNT = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  bam_pkg::t_event               i_event,
    input  logic [bam_pkg::PICK_W-1:0]    i_pick,
    input  logic [bam_pkg::TIMER_W-1:0]   i_toggle_period,
    input  logic [bam_pkg::TIMER_W-1:0]   i_sweep_period,
    input  logic [bam_pkg::TIMER_W-1:0]   i_random_period,
    output logic [LAMP_COUNT-1:0]         o_lamps,
    output bam_pkg::t_mode                o_mode
);
    import bam_pkg::*;

    localparam int PW = $clog2(LAMP_COUNT + 1);
    localparam int VW = 5;
    localparam logic [LAMP_COUNT-1:0] ALL_LAMPS = '1;
    localparam logic [LAMP_COUNT-1:0] ONE_LAMP  = LAMP_COUNT'(1);
    localparam logic [PW-1:0]         POS_LAST  = PW'(LAMP_COUNT - 1);
    localparam logic [PW-1:0]         POS_COUNT = PW'(LAMP_COUNT);
    localparam logic [VW-1:0]         PICK_MOD  = VW'(LAMP_COUNT);

    t_mode                r_mode, n_mode;
    logic [TIMER_W-1:0]   r_timer, n_timer;
    logic [PW-1:0]        r_pos, n_pos;
    logic                 r_fwd, n_fwd;
    logic [LAMP_COUNT-1:0] r_lamps, n_lamps;
    logic [VW-1:0]        pick_idx;

    // Fold the pick into range by repeated subtraction; pick is below 8.
    always_comb begin
        pick_idx = {{(VW-PICK_W){1'b0}}, i_pick};
        for (int k = 0; k < 3; k++) begin
            if (pick_idx >= PICK_MOD) begin
                pick_idx = pick_idx - PICK_MOD;
            end
        end
    end

    always_comb begin
        n_timer = sat_inc(r_timer);
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_fwd   = r_fwd;
        n_lamps = r_lamps;

        case (i_event)
            EV_SHORT: begin
                n_mode  = (r_mode == MODE_RANDOM || r_mode > MODE_RANDOM) ? MODE_OFF
                        : t_mode'(r_mode + 3'd1);
                n_lamps = '0;
                n_pos   = '0;
                n_fwd   = 1'b1;
            end
            EV_LONG: begin
                n_mode  = MODE_OFF;
                n_lamps = '0;
                n_fwd   = 1'b1;
            end
            default: ;
        endcase

        case (n_mode)
            MODE_ON: begin
                n_lamps = ALL_LAMPS;
            end
            MODE_TOGGLE: begin
                if (n_timer >= i_toggle_period) begin
                    n_lamps = ~n_lamps;
                    n_timer = '0;
                end
            end
            MODE_SWEEP: begin
                if (n_timer >= i_sweep_period) begin
                    n_lamps = (n_pos < POS_COUNT) ? (ONE_LAMP << n_pos) : '0;
                    if (n_fwd) begin
                        n_pos = n_pos + PW'(1);
                    end else if (n_pos != '0) begin
                        n_pos = n_pos - PW'(1);
                    end
                    // Flip at either end of the row.
                    if (n_pos >= POS_LAST || n_pos == '0) begin
                        n_fwd = ~n_fwd;
                    end
                    n_timer = '0;
                end
            end
            MODE_RANDOM: begin
                if (n_timer >= i_random_period) begin
                    n_lamps = ONE_LAMP << pick_idx;
                    n_timer = '0;
                end
            end
            default: begin
                n_lamps = '0;
            end
        endcase
    end

    assign o_lamps = n_lamps;
    assign o_mode  = n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ON;
            r_timer <= '0;
            r_pos   <= '0;
            r_fwd   <= 1'b1;
            r_lamps <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_timer <= n_timer;
            r_pos   <= n_pos;
            r_fwd   <= n_fwd;
            r_lamps <= n_lamps;
        end
    end

endmodule

/* rtl/core/button_mode_led_animator.sv */
// Button mode lamp animator: top level with input register, result register
// and configuration registers. Depends on bam_pkg, bam_button and bam_anim.
//
// Usage:
//   Send one item per millisecond tick on the input channel (i_in_valid /
//   o_in_ready / i_in): the active-low button level and a lamp pick for random
//   mode. Each item gives exactly one result on the output channel
//   (o_out_valid / i_out_ready / o_out): the lamp pattern, the display mode and
//   the press event seen on that tick.
//   An accepted item sits in the input register, and its tick is computed into
//   the result register when the stage steps, and the result is shown from the
//   result register. Throughput is one item per cycle while the receiver does
//   not stall; the tick update is a single pass of timer compares and counter
//   updates on the state word.
//   When the receiver stalls, the result register holds and the input
//   register fills, after which o_in_ready drops; nothing is lost.
//   Reset (synchronous, active low) empties both registers, loads the default
//   timings and sets the mode to all on with the lamps off.
//   Write configuration registers through i_cfg_we / i_cfg_idx / i_cfg_data
//   only while no item is in flight.
module button_mode_led_animator #(
    parameter int LAMP_COUNT = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bam_pkg::t_in_item               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bam_pkg::t_out_item              o_out,
    input  logic                            i_cfg_we,
    input  logic [bam_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bam_pkg::TIMER_W-1:0]     i_cfg_data
);
    import bam_pkg::*;

    localparam int LW = (LAMP_COUNT > LAMPS_W) ? LAMP_COUNT : LAMPS_W;

    logic [TIMER_W-1:0] r_debounce, r_long_press, r_toggle, r_sweep, r_random;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out, n_out;
    logic       step;

    t_event                 press_ev;
    logic [LAMP_COUNT-1:0]  lamps;
    t_mode                  mode;
    logic [LW-1:0]          lamps_wide;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_long_press <= LONG_PRESS_RST;
            r_toggle     <= TOGGLE_RST;
            r_sweep      <= SWEEP_RST;
            r_random     <= RANDOM_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                REG_LONG_PRESS: r_long_press <= i_cfg_data;
                REG_TOGGLE:     r_toggle     <= i_cfg_data;
                REG_SWEEP:      r_sweep      <= i_cfg_data;
                REG_RANDOM:     r_random     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: take a new item whenever the stage moves on or is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    bam_button u_button (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_pressed          (!r_in.button_level),
        .i_debounce_ticks   (r_debounce),
        .i_long_press_ticks (r_long_press),
        .o_event            (press_ev)
    );

    bam_anim #(
        .LAMP_COUNT (LAMP_COUNT)
    ) u_anim (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_event         (press_ev),
        .i_pick          (r_in.random_pick),
        .i_toggle_period (r_toggle),
        .i_sweep_period  (r_sweep),
        .i_random_period (r_random),
        .o_lamps         (lamps),
        .o_mode          (mode)
    );

    assign lamps_wide = LW'(lamps);

    always_comb begin
        n_out.lamps       = lamps_wide[LAMPS_W-1:0];
        n_out.mode        = mode;
        n_out.press_event = press_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A computed tick always lands in the result register.
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("tick computed but no result shown");

    // A long press leaves the mode off and the lamps dark.
    a_long_forces_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.press_event == EV_LONG) |->
            (o_out.mode == MODE_OFF && o_out.lamps == '0))
        else $error("long press did not force off");

    // Off mode never lights a lamp.
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.mode == MODE_OFF) |-> o_out.lamps == '0)
        else $error("lamps lit in off mode");

    // Mode code stays within the five modes.
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.mode <= MODE_RANDOM))
        else $error("mode code out of range");

endmodule
